FILE: hdl/rsmc_pkg.sv
// ----------------------------------------------------------------------------
// rsmc_pkg
// Types and constants shared by the reel slack mode controller modules.
// ----------------------------------------------------------------------------
package rsmc_pkg;

  // command codes
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_SPEED  = 2'd1;
  localparam logic [1:0] CMD_TORQUE = 2'd2;
  localparam logic [1:0] CMD_OFF    = 2'd3;

  // reel phase codes
  localparam logic [1:0] PHASE_OFF     = 2'd0;
  localparam logic [1:0] PHASE_REELING = 2'd1;
  localparam logic [1:0] PHASE_PAUSED  = 2'd2;
  localparam logic [1:0] PHASE_WATCH   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_SPEED_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_REEL_DELAY_MS   = 2'd1;
  localparam logic [1:0] REG_PAUSE_DELAY_MS  = 2'd2;
  localparam logic [1:0] REG_MAX_CURRENT_MA  = 2'd3;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // reset values
  localparam logic [14:0] SPEED_THRESHOLD_RST = 15'd1280;
  localparam logic [15:0] REEL_DELAY_MS_RST   = 16'd200;
  localparam logic [15:0] PAUSE_DELAY_MS_RST  = 16'd300;
  localparam logic [14:0] MAX_CURRENT_MA_RST  = 15'd1000;
  localparam logic signed [15:0] TARGET_RST   = 16'sd2560;

  typedef struct packed {
    logic [1:0]         cmd;
    logic               value_present;
    logic signed [15:0] command_value;
    logic [31:0]        now_ms;
    logic signed [15:0] measured_speed;
  } in_item_t;

  typedef struct packed {
    logic               motor_enabled;
    logic               drive_mode;
    logic signed [15:0] drive_target;
    logic [1:0]         reel_phase;
  } out_item_t;

  typedef struct packed {
    logic [14:0] speed_threshold;
    logic [15:0] reel_delay_ms;
    logic [15:0] pause_delay_ms;
    logic [14:0] max_current_ma;
  } cfg_t;

  typedef struct packed {
    logic               slack_active;
    logic               reel_running;
    logic               reel_paused;
    logic               unwind_seen;
    logic [31:0]        last_motion_time;
    logic [31:0]        pause_start_time;
    logic signed [15:0] target_reg;
    logic               enabled_reg;
    logic               mode_reg;
  } state_t;

endpackage

FILE: hdl/rsmc_step.sv
// ----------------------------------------------------------------------------
// rsmc_step
// Next-state and result logic for one command or control tick.
// ----------------------------------------------------------------------------
module rsmc_step (
  input  rsmc_pkg::state_t   state,
  input  rsmc_pkg::cfg_t     cfg,
  input  rsmc_pkg::in_item_t item,
  output rsmc_pkg::state_t   state_next,
  output rsmc_pkg::out_item_t result
);

  logic signed [16:0] spd;
  logic signed [16:0] thr;
  logic signed [16:0] thr_neg;
  logic               fwd_motion;
  logic               rev_motion;
  logic [31:0]        motion_time;
  logic [31:0]        motion_age;
  logic [31:0]        pause_age;
  logic               motion_expired;
  logic               pause_expired;
  logic signed [15:0] lim;
  logic signed [15:0] lim_neg;
  logic signed [15:0] torque_target;

  assign spd     = {item.measured_speed[15], item.measured_speed};
  assign thr     = {2'b00, cfg.speed_threshold};
  assign thr_neg = -thr;

  assign fwd_motion = spd > thr;
  assign rev_motion = spd < thr_neg;

  // motion timer as it stands after this tick's speed sample
  always_comb begin
    motion_time = state.last_motion_time;
    if (state.reel_running) begin
      if (fwd_motion) motion_time = item.now_ms;
    end else if (rev_motion) begin
      motion_time = item.now_ms;
    end
  end

  assign motion_age     = item.now_ms - motion_time;
  assign pause_age      = item.now_ms - state.pause_start_time;
  assign motion_expired = motion_age > {16'd0, cfg.reel_delay_ms};
  assign pause_expired  = pause_age > {16'd0, cfg.pause_delay_ms};

  assign lim     = {1'b0, cfg.max_current_ma};
  assign lim_neg = -lim;

  always_comb begin
    if (!item.command_value[15]) begin
      torque_target = (item.command_value < lim) ? item.command_value : lim;
    end else begin
      torque_target = (item.command_value > lim_neg) ? item.command_value : lim_neg;
    end
  end

  always_comb begin
    state_next = state;
    unique case (item.cmd)
      rsmc_pkg::CMD_SPEED: begin
        if (item.value_present) begin
          state_next.target_reg       = item.command_value;
          state_next.enabled_reg      = 1'b1;
          state_next.mode_reg         = 1'b1;
          state_next.slack_active     = 1'b1;
          state_next.reel_running     = 1'b1;
          state_next.last_motion_time = item.now_ms;
        end
      end
      rsmc_pkg::CMD_TORQUE: begin
        if (item.value_present) begin
          state_next.target_reg   = torque_target;
          state_next.enabled_reg  = 1'b1;
          state_next.mode_reg     = 1'b0;
          state_next.slack_active = 1'b0;
        end
      end
      rsmc_pkg::CMD_OFF: begin
        state_next.target_reg   = '0;
        state_next.enabled_reg  = 1'b0;
        state_next.slack_active = 1'b0;
      end
      default: begin
        if (state.slack_active) begin
          if (state.reel_running) begin
            state_next.last_motion_time = motion_time;
            if (motion_expired) begin
              state_next.enabled_reg      = 1'b0;
              state_next.reel_running     = 1'b0;
              state_next.reel_paused      = 1'b1;
              state_next.pause_start_time = item.now_ms;
            end
          end else if (state.reel_paused) begin
            if (pause_expired) state_next.reel_paused = 1'b0;
          end else begin
            state_next.last_motion_time = motion_time;
            if (rev_motion) state_next.unwind_seen = 1'b1;
            // unwind settled: resume reeling
            if ((state.unwind_seen || rev_motion) && motion_expired) begin
              state_next.enabled_reg      = 1'b1;
              state_next.unwind_seen      = 1'b0;
              state_next.reel_running     = 1'b1;
              state_next.last_motion_time = item.now_ms;
            end
          end
        end
      end
    endcase
  end

  always_comb begin
    result.motor_enabled = state_next.enabled_reg;
    result.drive_mode    = state_next.mode_reg;
    result.drive_target  = state_next.target_reg;
    priority if (!state_next.slack_active) result.reel_phase = rsmc_pkg::PHASE_OFF;
    else if (state_next.reel_running)      result.reel_phase = rsmc_pkg::PHASE_REELING;
    else if (state_next.reel_paused)       result.reel_phase = rsmc_pkg::PHASE_PAUSED;
    else                                   result.reel_phase = rsmc_pkg::PHASE_WATCH;
  end

endmodule

FILE: hdl/reel_slack_mode_controller_unit.sv
// ----------------------------------------------------------------------------
// reel_slack_mode_controller_unit
// Speed/torque/off mode control of a reel motor with slack-based reel stop,
// pause and unwind-triggered resume.
// ----------------------------------------------------------------------------
// Every input beat (a mode command or a control tick) yields one result beat
// with the drive state after that beat. A beat passes an input register and
// then the state update, which writes the result register; one beat is taken
// every cycle as long as the result side keeps taking beats. The rate is set
// by the state update loop. Configuration writes take effect the cycle after
// cfg_write.
module reel_slack_mode_controller_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  rsmc_pkg::in_item_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output rsmc_pkg::out_item_t                   out_data,
  input  logic                                  cfg_write,
  input  logic [rsmc_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [rsmc_pkg::CFG_DATA_W-1:0]       cfg_data
);

  rsmc_pkg::cfg_t      cfg;
  rsmc_pkg::state_t    state;
  rsmc_pkg::state_t    state_next;
  rsmc_pkg::in_item_t  item;
  rsmc_pkg::out_item_t result;
  logic                item_valid;
  logic                advance;

  assign advance  = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed_threshold <= rsmc_pkg::SPEED_THRESHOLD_RST;
      cfg.reel_delay_ms   <= rsmc_pkg::REEL_DELAY_MS_RST;
      cfg.pause_delay_ms  <= rsmc_pkg::PAUSE_DELAY_MS_RST;
      cfg.max_current_ma  <= rsmc_pkg::MAX_CURRENT_MA_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rsmc_pkg::REG_SPEED_THRESHOLD: cfg.speed_threshold <= cfg_data[14:0];
        rsmc_pkg::REG_REEL_DELAY_MS:   cfg.reel_delay_ms   <= cfg_data;
        rsmc_pkg::REG_PAUSE_DELAY_MS:  cfg.pause_delay_ms  <= cfg_data;
        rsmc_pkg::REG_MAX_CURRENT_MA:  cfg.max_current_ma  <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) item <= in_data;
  end

  rsmc_step u_step (
    .state      (state),
    .cfg        (cfg),
    .item       (item),
    .state_next (state_next),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.slack_active     <= 1'b0;
      state.reel_running     <= 1'b0;
      state.reel_paused      <= 1'b0;
      state.unwind_seen      <= 1'b0;
      state.last_motion_time <= '0;
      state.pause_start_time <= '0;
      state.target_reg       <= rsmc_pkg::TARGET_RST;
      state.enabled_reg      <= 1'b0;
      state.mode_reg         <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_data <= result;
  end

endmodule

FILE: test/rsmc_drive_monitor.sv
// ----------------------------------------------------------------------------
// rsmc_drive_monitor
// Watches the command/tick and drive-state channels of the reel slack mode
// controller. It keeps its own copy of the registers and the drive state,
// works out the drive state that each accepted beat leaves behind, and
// compares it field by field with the result beats in order.
// ----------------------------------------------------------------------------
module rsmc_drive_monitor
  import rsmc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  in_item_t               in_data,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  out_item_t              out_data,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatch_count,
  output int                     outstanding
);

  cfg_t      regs;
  state_t    drive;
  out_item_t drive_results[$];

  initial begin
    mismatch_count = 0;
    outstanding = 0;
  end

  // wrapping ms difference, strictly longer than the span
  function automatic logic elapsed(logic [31:0] now, logic [31:0] since,
                                   logic [15:0] span);
    logic [31:0] diff;
    diff = now - since;
    return diff > {16'd0, span};
  endfunction

  task automatic run_slack_tick(input logic [31:0] now, input int spd);
    int thr;
    thr = int'(regs.speed_threshold);
    if (drive.reel_running) begin
      if (spd > thr) drive.last_motion_time = now;
      if (elapsed(now, drive.last_motion_time, regs.reel_delay_ms)) begin
        drive.enabled_reg = 1'b0;
        drive.reel_running = 1'b0;
        drive.reel_paused = 1'b1;
        drive.pause_start_time = now;
      end
    end else if (drive.reel_paused) begin
      if (elapsed(now, drive.pause_start_time, regs.pause_delay_ms))
        drive.reel_paused = 1'b0;
    end else begin
      if (spd < -thr) begin
        drive.unwind_seen = 1'b1;
        drive.last_motion_time = now;
      end
      if (drive.unwind_seen && elapsed(now, drive.last_motion_time, regs.reel_delay_ms)) begin
        drive.enabled_reg = 1'b1;
        drive.unwind_seen = 1'b0;
        drive.reel_running = 1'b1;
        drive.last_motion_time = now;
      end
    end
  endtask

  task automatic update_drive(input in_item_t b, output out_item_t r);
    int val;
    int lim;
    val = int'(b.command_value);
    lim = int'(regs.max_current_ma);
    case (b.cmd)
      CMD_SPEED: begin
        if (b.value_present) begin
          drive.target_reg = b.command_value;
          drive.enabled_reg = 1'b1;
          drive.mode_reg = 1'b1;
          drive.slack_active = 1'b1;
          drive.reel_running = 1'b1;
          drive.last_motion_time = b.now_ms;
        end
      end
      CMD_TORQUE: begin
        if (b.value_present) begin
          if (val > lim) drive.target_reg = 16'(lim);
          else if (val < -lim) drive.target_reg = 16'(-lim);
          else drive.target_reg = b.command_value;
          drive.enabled_reg = 1'b1;
          drive.mode_reg = 1'b0;
          drive.slack_active = 1'b0;
        end
      end
      CMD_OFF: begin
        drive.target_reg = '0;
        drive.enabled_reg = 1'b0;
        drive.slack_active = 1'b0;
      end
      CMD_TICK: begin
        if (drive.slack_active) run_slack_tick(b.now_ms, int'(b.measured_speed));
      end
    endcase
    r.motor_enabled = drive.enabled_reg;
    r.drive_mode = drive.mode_reg;
    r.drive_target = drive.target_reg;
    if (!drive.slack_active) r.reel_phase = PHASE_OFF;
    else if (drive.reel_running) r.reel_phase = PHASE_REELING;
    else if (drive.reel_paused) r.reel_phase = PHASE_PAUSED;
    else r.reel_phase = PHASE_WATCH;
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (drive_results.size() == 0) begin
      $error("result beat with no drive state pending");
      mismatch_count++;
    end else begin
      want = drive_results.pop_front();
      if (got.motor_enabled !== want.motor_enabled) begin
        $error("motor_enabled: expected %0d, actual %0d", want.motor_enabled,
               got.motor_enabled);
        mismatch_count++;
      end
      if (got.drive_mode !== want.drive_mode) begin
        $error("drive_mode: expected %0d, actual %0d", want.drive_mode, got.drive_mode);
        mismatch_count++;
      end
      if (got.drive_target !== want.drive_target) begin
        $error("drive_target: expected %0d, actual %0d", want.drive_target,
               got.drive_target);
        mismatch_count++;
      end
      if (got.reel_phase !== want.reel_phase) begin
        $error("reel_phase: expected %0d, actual %0d", want.reel_phase, got.reel_phase);
        mismatch_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    out_item_t next_state;
    if (rst) begin
      regs.speed_threshold = SPEED_THRESHOLD_RST;
      regs.reel_delay_ms = REEL_DELAY_MS_RST;
      regs.pause_delay_ms = PAUSE_DELAY_MS_RST;
      regs.max_current_ma = MAX_CURRENT_MA_RST;
      drive = '0;
      drive.target_reg = TARGET_RST;
      drive_results.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_SPEED_THRESHOLD: regs.speed_threshold = cfg_data[14:0];
          REG_REEL_DELAY_MS:   regs.reel_delay_ms = cfg_data;
          REG_PAUSE_DELAY_MS:  regs.pause_delay_ms = cfg_data;
          REG_MAX_CURRENT_MA:  regs.max_current_ma = cfg_data[14:0];
        endcase
      end
      // check first so a beat never meets its own prediction
      if (out_valid && !out_stall) check_result(out_data);
      if (in_valid && !in_stall) begin
        update_drive(in_data, next_state);
        drive_results.push_back(next_state);
      end
    end
    outstanding = drive_results.size();
  end

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the reel slack mode controller with directed mode commands and
// reel/pause/unwind tick sequences, then random sessions under several
// register settings with bursty idling on both channels. The drive monitor
// beside the block predicts and checks every result beat.
// ----------------------------------------------------------------------------
module testbench;
  import rsmc_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int SESSION_BEATS = 80;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  in_item_t               in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_item_t              out_data;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int          mismatch_count;
  int          outstanding;
  int          idle_odds = 0;
  int          beats_sent = 0;
  int          quiet_cycles = 0;
  int          cur_thr = 1280;
  int          cur_reel = 200;
  int          cur_pause = 300;
  int          goal;
  logic [31:0] ms_clock;
  logic [31:0] t0;

  always #6 clk = ~clk;

  reel_slack_mode_controller_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rsmc_drive_monitor drive_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  // cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side stall bursts
  initial begin
    forever begin
      @(negedge clk);
      if (idle_odds > 0 && $urandom_range(1, 100) <= idle_odds) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  task automatic send_beat(input logic [1:0] cmd, input logic vp, input logic [15:0] val,
                           input logic [31:0] now, input logic [15:0] spd);
    @(negedge clk);
    if (idle_odds > 0 && $urandom_range(1, 100) <= idle_odds) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data.cmd = cmd;
    in_data.value_present = vp;
    in_data.command_value = val;
    in_data.now_ms = now;
    in_data.measured_speed = spd;
    do @(posedge clk); while (in_stall);
    // valueless speed/torque beats change nothing
    if (cmd == CMD_TICK || cmd == CMD_OFF || vp) beats_sent++;
  endtask

  task automatic send_noise();
    send_beat(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 16'($urandom), $urandom,
              16'($urandom));
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    in_valid = 1'b0;
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_index = idx;
    cfg_data = data;
    cfg_write = 1'b1;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic set_regs(input logic [15:0] thr, input logic [15:0] reel,
                          input logic [15:0] pause, input logic [15:0] max_ma);
    write_reg(REG_SPEED_THRESHOLD, thr);
    write_reg(REG_REEL_DELAY_MS, reel);
    write_reg(REG_PAUSE_DELAY_MS, pause);
    write_reg(REG_MAX_CURRENT_MA, max_ma);
    cur_thr = int'(thr[14:0]);
    cur_reel = int'(reel);
    cur_pause = int'(pause);
  endtask

  // 0 forward motion, 1 at or under the threshold, 2 unwinding
  function automatic int pick_speed(int kind);
    int v;
    if (kind == 0 && cur_thr < 32767) begin
      if ($urandom_range(0, 3) == 0) v = cur_thr + 1;
      else v = int'($urandom_range(cur_thr + 1, 32767));
    end else if (kind == 2) begin
      if ($urandom_range(0, 3) == 0) v = -cur_thr - 1;
      else v = -int'($urandom_range(cur_thr + 1, 32768));
    end else begin
      if ($urandom_range(0, 3) == 0) v = $urandom_range(0, 1) ? cur_thr : -cur_thr;
      else v = int'($urandom_range(0, 2 * cur_thr)) - cur_thr;
    end
    return v;
  endfunction

  task automatic reel_session();
    int segs;
    int len;
    int kind;
    int span;
    case ($urandom_range(0, 9))
      0: send_beat(CMD_TORQUE, 1'b1, 16'($urandom), ms_clock, 16'($urandom));
      1: send_beat(CMD_OFF, 1'($urandom_range(0, 1)), 16'($urandom), ms_clock, 16'($urandom));
      2: send_noise();
      default: ;
    endcase
    send_beat(CMD_SPEED, $urandom_range(0, 9) != 0, 16'($urandom), ms_clock, 16'($urandom));
    span = cur_reel + cur_pause;
    segs = $urandom_range(2, 6);
    repeat (segs) begin
      kind = $urandom_range(0, 2);
      len = $urandom_range(1, 6);
      repeat (len) begin
        if ($urandom_range(0, 19) == 0) begin
          send_noise();
        end else begin
          if ($urandom_range(0, 19) == 0) ms_clock += $urandom;
          else ms_clock += $urandom_range(0, span / 3 + 2);
          send_beat(CMD_TICK, 1'($urandom_range(0, 1)), 16'($urandom), ms_clock,
                    16'(pick_speed(kind)));
        end
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: mode commands, clamp extremes, then a full reel cycle across the
    // 32-bit ms wrap with every compare hit at its boundary
    idle_odds = 15;
    t0 = 32'hFFFF_FF00;
    send_beat(CMD_TICK, 1'b1, 16'h7FFF, 32'h0, 16'h8000);
    send_beat(CMD_SPEED, 1'b0, 16'h1234, 32'h0, 16'h0);
    send_beat(CMD_TORQUE, 1'b0, 16'h0100, 32'h0, 16'h0);
    send_beat(CMD_TORQUE, 1'b1, 16'h7FFF, 32'h0, 16'h0);
    send_beat(CMD_TORQUE, 1'b1, 16'h8000, 32'h0, 16'h0);
    send_beat(CMD_TORQUE, 1'b1, 16'h0000, 32'h0, 16'h0);
    send_beat(CMD_TORQUE, 1'b1, -16'sd999, 32'h0, 16'h0);
    send_beat(CMD_OFF, 1'b1, 16'h5555, 32'hFFFF_FFFF, 16'h7FFF);
    send_beat(CMD_SPEED, 1'b1, 16'h7FFF, t0, 16'h0);
    send_beat(CMD_TICK, 1'b0, 16'h0, t0 + 32'd100, 16'sd1281);
    send_beat(CMD_TICK, 1'b0, 16'h0, t0 + 32'd300, 16'sd1280);
    send_beat(CMD_TICK, 1'b0, 16'h0, t0 + 32'd301, -16'sd1280);
    send_beat(CMD_TICK, 1'b0, 16'h0, t0 + 32'd601, -16'sd5000);
    send_beat(CMD_TICK, 1'b0, 16'h0, t0 + 32'd602, 16'h0);
    send_beat(CMD_TICK, 1'b0, 16'h0, t0 + 32'd603, -16'sd1281);
    send_beat(CMD_TICK, 1'b0, 16'h0, t0 + 32'd803, 16'h0);
    send_beat(CMD_TICK, 1'b0, 16'h0, t0 + 32'd804, 16'h7FFF);
    send_beat(CMD_TORQUE, 1'b1, 16'sd500, t0 + 32'd805, 16'h0);
    send_beat(CMD_TICK, 1'b0, 16'h0, t0 + 32'd5000, 16'h8000);
    send_beat(CMD_SPEED, 1'b1, 16'h8000, t0 + 32'd900, 16'h0);
    send_beat(CMD_OFF, 1'b0, 16'h0, t0 + 32'd901, 16'h0);
    send_beat(CMD_SPEED, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 16'h0);
    send_beat(CMD_TICK, 1'b1, 16'hFFFF, 32'h0000_00C8, 16'h8000);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: idle_odds = 10;
        1: begin
          set_regs(16'd0, 16'd0, 16'd0, 16'd0);
          idle_odds = 30;
        end
        2: begin
          // top bit of the 15-bit registers must be dropped
          set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
          idle_odds = 5;
        end
        3: begin
          set_regs(16'd300, 16'd20, 16'd30, 16'd500);
          idle_odds = 20;
        end
        4: begin
          set_regs(16'($urandom_range(0, 4000)), 16'($urandom_range(1, 100)),
                   16'($urandom_range(1, 100)), 16'($urandom));
          idle_odds = 15;
        end
        default: begin
          set_regs(16'd1280, 16'd50, 16'd60, 16'd2000);
          idle_odds = 0;
        end
      endcase
      ms_clock = $urandom;
      goal = beats_sent + SESSION_BEATS;
      while (beats_sent < goal) reel_session();
    end

    @(negedge clk);
    in_valid = 1'b0;
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/rsmc_pkg.sv
hdl/rsmc_step.sv
hdl/reel_slack_mode_controller_unit.sv
test/rsmc_drive_monitor.sv
test/testbench.sv
